// File: src/crchst_pkg.sv
// ----------------------------------------------------------------------------
// crchst_pkg
// Shared constants and types for the CRC-32 hash and sorted table match unit.
// ----------------------------------------------------------------------------
package crchst_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int CFG_W       = 11;
  localparam int ENTRY_W     = 10;

  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] CRC_START = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_LO    = 8'b0000_0100,
    S_HI    = 8'b0000_1000,
    S_PROBE = 8'b0001_0000,
    S_NEXT  = 8'b0010_0000,
    S_MARK  = 8'b0100_0000,
    S_RES   = 8'b1000_0000
  } state_t;

endpackage

// File: src/crc32_hash_sorted_table_match_unit.sv
// ----------------------------------------------------------------------------
// crc32_hash_sorted_table_match_unit
// Reflected CRC-32 over a byte stream, then a halving search of a sorted hash
// table held in block memory, with a claimed mark per entry.
// ----------------------------------------------------------------------------
// Write, clear and non-last byte items are taken in S_IDLE and leave the input open.
// A last byte goes through S_LO and S_HI (checks against the first and last
//   entries), S_PROBE (one memory read per probe), S_NEXT/S_MARK, S_RES.
// Only one lookup is in flight; the input stalls until it is in the output reg.
// Reset: synchronous; then a pass over every entry clears the claimed marks,
//   with the input stalled (configuration writes are still taken).
// ----------------------------------------------------------------------------
module crc32_hash_sorted_table_match_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [crchst_pkg::CFG_W-1:0]      cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_kind,
  input  logic [crchst_pkg::ENTRY_W-1:0]    in_entry_index,
  input  logic [31:0]                       in_entry_hash,
  input  logic [7:0]                        in_data_byte,
  input  logic                              in_last_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [31:0]                       out_crc_value,
  output logic                              out_found,
  output logic [crchst_pkg::ENTRY_W-1:0]    out_found_index,
  output logic                              out_newly_claimed
);

  localparam int IW = crchst_pkg::IDX_W;
  localparam int CW = crchst_pkg::CNT_W;
  localparam int CFG_WL = crchst_pkg::CFG_W;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c;
    for (int i = 0; i < 8; i++) begin
      r = {1'b0, r[31:1]} ^ ((r[0] ^ b[i]) ? crchst_pkg::CRC_POLY : 32'd0);
    end
    return r;
  endfunction

  crchst_pkg::state_t state_r, state_nxt;

  logic [31:0]    crc_r, crc_nxt;
  logic [31:0]    h_r, h_nxt;
  logic [IW-1:0]  pos_r, pos_nxt;
  logic [IW-1:0]  lo_r, lo_nxt;
  logic [IW-1:0]  hi_r, hi_nxt;
  logic [IW-1:0]  clr_r, clr_nxt;
  logic [CFG_WL-1:0] cnt_r;

  logic           res_found_r, res_found_nxt;
  logic [IW-1:0]  res_idx_r, res_idx_nxt;
  logic           res_new_r, res_new_nxt;

  logic           out_valid_r, out_valid_nxt;
  logic [31:0]    out_crc_r, out_crc_nxt;
  logic           out_found_r, out_found_nxt;
  logic [IW-1:0]  out_idx_r, out_idx_nxt;
  logic           out_new_r, out_new_nxt;

  logic [31:0]    hash_mem [crchst_pkg::TABLE_DEPTH];
  logic           hm_we;
  logic [IW-1:0]  hm_raddr;
  logic [31:0]    hm_rdata_r;

  logic           mark_mem [crchst_pkg::TABLE_DEPTH];
  logic           mk_we;
  logic [IW-1:0]  mk_waddr;
  logic           mk_wdata;
  logic [IW-1:0]  mk_raddr;
  logic           mk_rdata_r;

  logic [CW-1:0]  eff;
  logic [CW-1:0]  idx_ext;
  logic [CW-1:0]  pos_inc;
  logic [IW-1:0]  mid_up;
  logic [IW-1:0]  mid_dn;
  logic [IW-1:0]  np;
  logic [31:0]    crc_new;

  always_comb begin
    if (cnt_r > CFG_WL'(crchst_pkg::TABLE_DEPTH)) begin
      eff = CW'(crchst_pkg::TABLE_DEPTH);
    end else begin
      eff = CW'(cnt_r);
    end
  end

  assign idx_ext = CW'(in_entry_index);
  assign pos_inc = {1'b0, pos_r} + CW'(1);
  assign mid_up  = IW'(({1'b0, pos_r} + {1'b0, hi_r}) >> 1);
  assign mid_dn  = IW'(({1'b0, lo_r} + {1'b0, pos_r}) >> 1);
  assign np      = (h_r > hm_rdata_r) ? mid_up : mid_dn;
  assign crc_new = crc_byte(crc_r, in_data_byte);

  assign in_stall = (state_r != crchst_pkg::S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    crc_nxt       = crc_r;
    h_nxt         = h_r;
    pos_nxt       = pos_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    clr_nxt       = clr_r;
    res_found_nxt = res_found_r;
    res_idx_nxt   = res_idx_r;
    res_new_nxt   = res_new_r;
    hm_we         = 1'b0;
    hm_raddr      = '0;
    mk_we         = 1'b0;
    mk_waddr      = pos_r;
    mk_wdata      = 1'b0;
    mk_raddr      = pos_r;

    out_valid_nxt = out_valid_r & out_stall;
    out_crc_nxt   = out_crc_r;
    out_found_nxt = out_found_r;
    out_idx_nxt   = out_idx_r;
    out_new_nxt   = out_new_r;

    unique case (state_r)
      crchst_pkg::S_CLEAR: begin
        mk_we    = 1'b1;
        mk_waddr = clr_r;
        clr_nxt  = clr_r + IW'(1);
        if (clr_r == IW'(crchst_pkg::TABLE_DEPTH - 1)) begin
          state_nxt = crchst_pkg::S_IDLE;
        end
      end
      crchst_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (in_kind)
            crchst_pkg::KIND_WRITE: begin
              if (idx_ext < CW'(crchst_pkg::TABLE_DEPTH)) begin
                hm_we    = 1'b1;
                mk_we    = 1'b1;
                mk_waddr = IW'(in_entry_index);
              end
            end
            crchst_pkg::KIND_CLEAR: begin
              if (idx_ext < eff) begin
                mk_we    = 1'b1;
                mk_waddr = IW'(in_entry_index);
              end
            end
            crchst_pkg::KIND_BYTE: begin
              if (in_last_byte) begin
                h_nxt   = crc_new;
                crc_nxt = crchst_pkg::CRC_START;
                if (eff == '0) begin
                  res_found_nxt = 1'b0;
                  res_idx_nxt   = '0;
                  res_new_nxt   = 1'b0;
                  state_nxt     = crchst_pkg::S_RES;
                end else begin
                  hm_raddr  = '0;
                  state_nxt = crchst_pkg::S_LO;
                end
              end else begin
                crc_nxt = crc_new;
              end
            end
            default: begin
            end
          endcase
        end
      end
      crchst_pkg::S_LO: begin
        if (h_r < hm_rdata_r) begin
          res_found_nxt = 1'b0;
          res_idx_nxt   = '0;
          res_new_nxt   = 1'b0;
          state_nxt     = crchst_pkg::S_RES;
        end else begin
          hm_raddr  = IW'(eff - CW'(1));
          state_nxt = crchst_pkg::S_HI;
        end
      end
      crchst_pkg::S_HI: begin
        if (h_r > hm_rdata_r) begin
          res_found_nxt = 1'b0;
          res_idx_nxt   = '0;
          res_new_nxt   = 1'b0;
          state_nxt     = crchst_pkg::S_RES;
        end else begin
          pos_nxt   = IW'(eff >> 1);
          lo_nxt    = '0;
          hi_nxt    = IW'(eff - CW'(1));
          hm_raddr  = IW'(eff >> 1);
          state_nxt = crchst_pkg::S_PROBE;
        end
      end
      crchst_pkg::S_PROBE: begin
        if (h_r == hm_rdata_r) begin
          state_nxt = crchst_pkg::S_MARK;
        end else begin
          if (h_r > hm_rdata_r) begin
            lo_nxt = pos_r;
          end else begin
            hi_nxt = pos_r;
          end
          if (np == pos_r) begin
            if (pos_inc < eff) begin
              pos_nxt   = IW'(pos_inc);
              hm_raddr  = IW'(pos_inc);
              state_nxt = crchst_pkg::S_NEXT;
            end else begin
              res_found_nxt = 1'b0;
              res_idx_nxt   = '0;
              res_new_nxt   = 1'b0;
              state_nxt     = crchst_pkg::S_RES;
            end
          end else begin
            pos_nxt  = np;
            hm_raddr = np;
          end
        end
      end
      crchst_pkg::S_NEXT: begin
        if (h_r == hm_rdata_r) begin
          state_nxt = crchst_pkg::S_MARK;
        end else begin
          res_found_nxt = 1'b0;
          res_idx_nxt   = '0;
          res_new_nxt   = 1'b0;
          state_nxt     = crchst_pkg::S_RES;
        end
      end
      crchst_pkg::S_MARK: begin
        mk_we         = 1'b1;
        mk_waddr      = pos_r;
        mk_wdata      = 1'b1;
        res_found_nxt = 1'b1;
        res_idx_nxt   = pos_r;
        res_new_nxt   = ~mk_rdata_r;
        state_nxt     = crchst_pkg::S_RES;
      end
      crchst_pkg::S_RES: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_crc_nxt   = h_r;
          out_found_nxt = res_found_r;
          out_idx_nxt   = res_idx_r;
          out_new_nxt   = res_new_r;
          state_nxt     = crchst_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = crchst_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (hm_we) begin
      hash_mem[IW'(in_entry_index)] <= in_entry_hash;
    end
    hm_rdata_r <= hash_mem[hm_raddr];
  end

  always_ff @(posedge clk) begin
    if (mk_we) begin
      mark_mem[mk_waddr] <= mk_wdata;
    end
    mk_rdata_r <= mark_mem[mk_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= crchst_pkg::S_CLEAR;
      clr_r       <= '0;
      crc_r       <= crchst_pkg::CRC_START;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cnt_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    h_r         <= h_nxt;
    pos_r       <= pos_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    res_found_r <= res_found_nxt;
    res_idx_r   <= res_idx_nxt;
    res_new_r   <= res_new_nxt;
    out_crc_r   <= out_crc_nxt;
    out_found_r <= out_found_nxt;
    out_idx_r   <= out_idx_nxt;
    out_new_r   <= out_new_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_crc_value     = out_crc_r;
  assign out_found         = out_found_r;
  assign out_found_index   = crchst_pkg::ENTRY_W'(out_idx_r);
  assign out_newly_claimed = out_new_r;

endmodule

// File: src/crchst_checker.sv
// ----------------------------------------------------------------------------
// crchst_checker
// Port-level checks for the CRC-32 hash and sorted table match unit.
// ----------------------------------------------------------------------------
module crchst_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_stall,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [31:0]                       out_crc_value,
  input  logic                              out_found,
  input  logic [crchst_pkg::ENTRY_W-1:0]    out_found_index,
  input  logic                              out_newly_claimed
);

  // mark clear pass follows reset
  a_reset_stall: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input not stalled after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_crc_value))
    else $error("stalled result dropped or changed");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_found_index == '0 && !out_newly_claimed)
    else $error("miss result carries index or claim");

  // a new result is loaded only while the input is held off
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while input was open");

endmodule

bind crc32_hash_sorted_table_match_unit crchst_checker u_crchst_checker (.*);
